// ===== rtl/pair_key_table_binary_search_assert.svh =====
// Assertion macros used by the checker file.
`ifndef PAIR_KEY_TABLE_BINARY_SEARCH_ASSERT_SVH
`define PAIR_KEY_TABLE_BINARY_SEARCH_ASSERT_SVH

// Checked only while out of reset.
`define PKBS_ASSERT_ON(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every edge, reset cycles included.
`define PKBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/pkbs_pkg.sv =====
package pkbs_pkg;

    // Field widths
    localparam int CODE_W   = 21;
    localparam int INDEX_W  = 12;
    localparam int AMOUNT_W = 16;
    localparam int COUNT_W  = 13;
    localparam int KEY_W    = 2 * CODE_W;
    localparam int ENTRY_W  = KEY_W + AMOUNT_W;

    localparam int DEFAULT_TABLE_DEPTH = 4096;

    // Item opcodes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Command kinds decided by the front end
    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_LOOKUP = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;

    // One queued command
    typedef struct packed {
        logic [1:0]          kind;
        logic [INDEX_W-1:0]  index;
        logic [CODE_W-1:0]   first_code;
        logic [CODE_W-1:0]   second_code;
        logic [AMOUNT_W-1:0] amount;
        logic [COUNT_W-1:0]  count;
    } cmd_t;

endpackage

// ===== rtl/pkbs_front.sv =====
module pkbs_front #(
    parameter int TABLE_DEPTH = pkbs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic        [pkbs_pkg::COUNT_W-1:0] cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_op,
    input  logic        [pkbs_pkg::INDEX_W-1:0] s_index,
    input  logic        [pkbs_pkg::CODE_W-1:0]  s_first_code,
    input  logic        [pkbs_pkg::CODE_W-1:0]  s_second_code,
    input  logic signed [pkbs_pkg::AMOUNT_W-1:0] s_write_amount,
    input  logic                                q_full,
    output logic                                q_push,
    output pkbs_pkg::cmd_t                      q_cmd
);

    logic [pkbs_pkg::COUNT_W-1:0] entry_count_reg;
    logic [pkbs_pkg::COUNT_W-1:0] count_eff;
    logic                         in_range;
    logic                         keep;

    // Entry count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
        end else if (cfg_wr_en) begin
            entry_count_reg <= cfg_wr_data;
        end
    end

    // Clamp count to the table size
    assign count_eff = (32'(entry_count_reg) > TABLE_DEPTH) ?
                       pkbs_pkg::COUNT_W'(TABLE_DEPTH) : entry_count_reg;

    // Classify: out-of-range writes are taken and dropped
    assign in_range = (32'(s_index) < TABLE_DEPTH);
    assign keep     = (s_op == pkbs_pkg::OP_LOOKUP) || in_range;

    always_comb begin
        q_cmd.index       = s_index;
        q_cmd.first_code  = s_first_code;
        q_cmd.second_code = s_second_code;
        q_cmd.amount      = s_write_amount;
        q_cmd.count       = count_eff;
        if (s_op == pkbs_pkg::OP_WRITE) begin
            q_cmd.kind = pkbs_pkg::KIND_WRITE;
        end else if (count_eff == '0) begin
            q_cmd.kind = pkbs_pkg::KIND_EMPTY;
        end else begin
            q_cmd.kind = pkbs_pkg::KIND_LOOKUP;
        end
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready && keep;

endmodule

// ===== rtl/pkbs_fifo.sv =====
module pkbs_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  pkbs_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output pkbs_pkg::cmd_t head_cmd
);

    // Two-entry command queue
    pkbs_pkg::cmd_t slot_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     fill_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   fill_reg <= fill_reg + 2'd1;
                2'b01:   fill_reg <= fill_reg - 2'd1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

    assign full     = (fill_reg == 2'd2);
    assign valid    = (fill_reg != 2'd0);
    assign head_cmd = slot_reg[rd_ptr_reg];

endmodule

// ===== rtl/pkbs_back.sv =====
module pkbs_back #(
    parameter int TABLE_DEPTH = pkbs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 q_valid,
    input  pkbs_pkg::cmd_t                       q_cmd,
    output logic                                 q_pop,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_found,
    output logic signed [pkbs_pkg::AMOUNT_W-1:0] m_amount
);

    localparam int ADDR_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int BOUND_W = $clog2(TABLE_DEPTH + 1);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_SEARCH = 1'b1;

    // Midpoint of [lo, hi), hi > lo
    function automatic logic [ADDR_W-1:0] mid_of(input logic [BOUND_W-1:0] lo,
                                                 input logic [BOUND_W-1:0] hi);
        logic [BOUND_W:0] sum;
        sum = {1'b0, lo} + {1'b0, hi} - (BOUND_W + 1)'(1);
        return ADDR_W'(sum >> 1);
    endfunction

    logic [pkbs_pkg::ENTRY_W-1:0] mem [TABLE_DEPTH];

    logic                          state_reg, state_next;
    logic [BOUND_W-1:0]            lo_reg, lo_next;
    logic [BOUND_W-1:0]            hi_reg, hi_next;
    logic [ADDR_W-1:0]             mid_reg, mid_next;
    logic [pkbs_pkg::KEY_W-1:0]    key_reg, key_next;
    logic [pkbs_pkg::ENTRY_W-1:0]  rd_data_reg;
    logic                          out_valid_reg, out_valid_next;
    logic                          found_reg, found_next;
    logic [pkbs_pkg::AMOUNT_W-1:0] amount_reg, amount_next;

    logic                          start_ok;
    logic                          mem_we;
    logic [ADDR_W-1:0]             rd_addr;
    logic [pkbs_pkg::KEY_W-1:0]    probe_key;
    logic                          hit;
    logic                          below;
    logic [BOUND_W-1:0]            nlo;
    logic [BOUND_W-1:0]            nhi;
    logic [BOUND_W-1:0]            count_b;

    // Table memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[ADDR_W'(q_cmd.index)] <= {q_cmd.first_code, q_cmd.second_code, q_cmd.amount};
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    // Probe compare and next bounds
    assign probe_key = rd_data_reg[pkbs_pkg::ENTRY_W-1 -: pkbs_pkg::KEY_W];
    assign hit       = (probe_key == key_reg);
    assign below     = (probe_key < key_reg);
    assign nlo       = below ? (BOUND_W'(mid_reg) + BOUND_W'(1)) : lo_reg;
    assign nhi       = below ? hi_reg : BOUND_W'(mid_reg);
    assign count_b   = BOUND_W'(q_cmd.count);

    // Result slot is free now or is emptied this cycle
    assign start_ok = !out_valid_reg || m_ready;

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        found_next     = found_reg;
        amount_next    = amount_reg;
        out_valid_next = out_valid_reg && !m_ready;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        rd_addr        = mid_of(lo_next, count_b);
        unique case (state_reg)
            ST_IDLE: begin
                rd_addr = mid_of('0, count_b);
                if (q_valid) begin
                    unique case (q_cmd.kind)
                        pkbs_pkg::KIND_WRITE: begin
                            q_pop  = 1'b1;
                            mem_we = 1'b1;
                        end
                        pkbs_pkg::KIND_LOOKUP: begin
                            if (start_ok) begin
                                q_pop      = 1'b1;
                                lo_next    = '0;
                                hi_next    = count_b;
                                mid_next   = mid_of('0, count_b);
                                key_next   = {q_cmd.first_code, q_cmd.second_code};
                                state_next = ST_SEARCH;
                            end
                        end
                        default: begin
                            if (start_ok) begin
                                q_pop          = 1'b1;
                                out_valid_next = 1'b1;
                                found_next     = 1'b0;
                                amount_next    = '0;
                            end
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                rd_addr = mid_of(nlo, nhi);
                if (hit) begin
                    out_valid_next = 1'b1;
                    found_next     = 1'b1;
                    amount_next    = rd_data_reg[pkbs_pkg::AMOUNT_W-1:0];
                    state_next     = ST_IDLE;
                end else if (nlo < nhi) begin
                    lo_next  = nlo;
                    hi_next  = nhi;
                    mid_next = mid_of(nlo, nhi);
                end else begin
                    out_valid_next = 1'b1;
                    found_next     = 1'b0;
                    amount_next    = '0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Search and result payload
    always_ff @(posedge aclk) begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        key_reg    <= key_next;
        found_reg  <= found_next;
        amount_reg <= amount_next;
    end

    assign m_valid  = out_valid_reg;
    assign m_found  = found_reg;
    assign m_amount = $signed(amount_reg);

endmodule

// ===== rtl/pair_key_table_binary_search.sv =====
// From the input transfer, with the queue empty and the result slot free: a write passes the
// queue, updates the table and gives no result; an empty count gives a miss on m_valid.
// Lookup with entry_count N: the first read is issued, then up to
// floor(log2 N)+1 probes are made before m_valid rises.
// One lookup at a time: no queued command is taken while a search is in progress.
// Reset (aresetn low, synchronous) clears count, queue and result; the table is not reset.
module pair_key_table_binary_search #(
    parameter int TABLE_DEPTH = pkbs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic        [pkbs_pkg::COUNT_W-1:0]  cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_op,
    input  logic        [pkbs_pkg::INDEX_W-1:0]  s_index,
    input  logic        [pkbs_pkg::CODE_W-1:0]   s_first_code,
    input  logic        [pkbs_pkg::CODE_W-1:0]   s_second_code,
    input  logic signed [pkbs_pkg::AMOUNT_W-1:0] s_write_amount,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_found,
    output logic signed [pkbs_pkg::AMOUNT_W-1:0] m_amount
);

    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_valid;
    pkbs_pkg::cmd_t push_cmd;
    pkbs_pkg::cmd_t head_cmd;

    // Accept and classify
    pkbs_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_index        (s_index),
        .s_first_code   (s_first_code),
        .s_second_code  (s_second_code),
        .s_write_amount (s_write_amount),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_cmd          (push_cmd)
    );

    // Command queue
    pkbs_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head_cmd (head_cmd)
    );

    // Table and search
    pkbs_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (head_cmd),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_found  (m_found),
        .m_amount (m_amount)
    );

endmodule

// ===== rtl/pkbs_checker.sv =====
`include "pair_key_table_binary_search_assert.svh"

module pkbs_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic                                 m_found,
    input logic signed [pkbs_pkg::AMOUNT_W-1:0] m_amount
);

    // No result straight out of reset
    `PKBS_ASSERT_ALWAYS(a_reset_no_result, aclk, !aresetn |=> !m_valid, "result after reset")

    // Stalled input stays offered
    `PKBS_ASSERT_ON(a_in_hold, aclk, aresetn, s_valid && !s_ready |=> s_valid, "input dropped")

    // A miss carries a zero amount
    `PKBS_ASSERT_ON(a_miss_zero, aclk, aresetn, m_valid && !m_found |-> m_amount == '0, "miss amount")

    // Stalled result stays offered
    `PKBS_ASSERT_ON(a_hold_valid, aclk, aresetn, m_valid && !m_ready |=> m_valid, "result dropped")

    // Stalled result payload holds
    `PKBS_ASSERT_ON(a_hold_data, aclk, aresetn, m_valid && !m_ready |=> $stable(m_amount) && $stable(m_found), "result changed")

endmodule

bind pair_key_table_binary_search pkbs_checker u_pkbs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_found  (m_found),
    .m_amount (m_amount)
);
